### sv/chained_hash_dictionary_defines.svh
// Assertion macros used by the dictionary's top module.
`ifndef CHAINED_HASH_DICTIONARY_DEFINES_SVH
`define CHAINED_HASH_DICTIONARY_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CHD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CHD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/chd_pkg.sv
// Types, constants and the bucket hash of the chained hash dictionary.
package chd_pkg;

   localparam int BUCKETS          = 16;
   localparam int SLOTS_PER_BUCKET = 8;
   localparam int KEY_BITS         = 32;
   localparam int VALUE_BITS       = 32;
   localparam int HASH_SHIFT       = 2;
   localparam int CMD_BITS         = 3;
   localparam int COUNT_BITS       = 8;

   localparam int BUCKET_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SLOT_BITS   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int FILL_BITS   = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int ENTRY_BITS  = KEY_BITS + VALUE_BITS;
   localparam int ROW_BITS    = SLOTS_PER_BUCKET * ENTRY_BITS;
   localparam int TOTAL_SLOTS = BUCKETS * SLOTS_PER_BUCKET;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOOKUP  = 3'd0,
      CMD_REPLACE = 3'd1,
      CMD_ABSENT  = 3'd2,
      CMD_DELETE  = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [KEY_BITS-1:0] key,
                                                        input logic mode);
      logic [KEY_BITS-1:0] shifted;
      shifted = mode ? (key >> HASH_SHIFT) : key;
      return shifted[BUCKET_BITS-1:0];
   endfunction

endpackage

### sv/chd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module chd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/chained_hash_dictionary.sv
// Top level of the chained hash dictionary: bucket memory, slot compare and write-back.
//
// Usage:
// An item is taken at a rising edge where start is high and busy is low; it
// carries req_cmd, req_key and req_value_in. Every item gives exactly one
// result on the rsp_ ports, marked by rsp_valid for one cycle; the receiver
// cannot hold it off. The bucket row is read at the accepting edge, the
// compare state then compares all slots of the row in parallel and the
// write-back state writes the row back and registers the result, which the
// receiver takes from the result registers while rsp_valid is high. busy is
// high during the compare and write-back states, so a new item can be taken
// at the edge that ends the cycle in which the previous result is shown; an
// item is not taken before the previous one is through. This is set by the
// read-modify-write of one bucket row in the single bucket memory.
// The hash mode is written through the csr_ channel, which is always ready; it
// is to be written only while no item is in flight; the block does not enforce this.
// Synchronous reset holds busy high, empties every bucket, zeroes the entry
// count and the hash mode; slot contents stay as they are and are read only
// once written.
`include "chained_hash_dictionary_defines.svh"

module chained_hash_dictionary (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [chd_pkg::CMD_BITS-1:0]     req_cmd,
   input  logic [chd_pkg::KEY_BITS-1:0]     req_key,
   input  logic [chd_pkg::VALUE_BITS-1:0]   req_value_in,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [chd_pkg::VALUE_BITS-1:0]   rsp_value_out,
   output logic                             rsp_bucket_full,
   output logic [chd_pkg::COUNT_BITS-1:0]   rsp_entry_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_hash_mode
);

   chd_pkg::state_type state_ff, state_in;

   logic                                  hash_mode_ff;
   chd_pkg::cmd_type                      cmd_ff;
   logic [chd_pkg::KEY_BITS-1:0]          key_ff;
   logic [chd_pkg::VALUE_BITS-1:0]        value_ff;
   logic [chd_pkg::BUCKET_BITS-1:0]       bucket_ff;
   logic [chd_pkg::FILL_BITS-1:0]         fill_ff;
   logic [chd_pkg::SLOTS_PER_BUCKET-1:0]  hit_vec_ff, hit_vec_in;
   logic [chd_pkg::FILL_BITS-1:0]         bucket_fill_ff [chd_pkg::BUCKETS];
   logic [chd_pkg::COUNT_BITS-1:0]        entry_count_ff, entry_count_in;

   logic                                  rsp_valid_ff;
   logic                                  rsp_found_ff, rsp_found_in;
   logic [chd_pkg::VALUE_BITS-1:0]        rsp_value_ff, rsp_value_in;
   logic                                  rsp_full_ff, rsp_full_in;

   logic                                  accept;
   logic [chd_pkg::BUCKET_BITS-1:0]       req_bucket;
   logic [chd_pkg::ROW_BITS-1:0]          row_rd;
   logic [chd_pkg::ROW_BITS-1:0]          row_wr;
   logic                                  row_we;
   logic                                  fill_we;
   logic                                  fill_clr;
   logic [chd_pkg::FILL_BITS-1:0]         fill_new;

   logic [chd_pkg::KEY_BITS-1:0]          slot_key   [chd_pkg::SLOTS_PER_BUCKET];
   logic [chd_pkg::VALUE_BITS-1:0]        slot_value [chd_pkg::SLOTS_PER_BUCKET];
   logic [chd_pkg::KEY_BITS-1:0]          new_key    [chd_pkg::SLOTS_PER_BUCKET];
   logic [chd_pkg::VALUE_BITS-1:0]        new_value  [chd_pkg::SLOTS_PER_BUCKET];
   logic [chd_pkg::SLOT_BITS-1:0]         hit_idx;
   logic [chd_pkg::SLOT_BITS-1:0]         last_idx;
   logic [chd_pkg::SLOT_BITS-1:0]         free_idx;
   logic                                  hit_any;

   assign accept     = start && !busy;
   assign busy       = reset || (state_ff != chd_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_bucket = chd_pkg::bucket_of(req_key, hash_mode_ff);

   chd_ram #(
      .WIDTH(chd_pkg::ROW_BITS),
      .DEPTH(chd_pkg::BUCKETS)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (bucket_ff),
      .wr_data (row_wr),
      .rd_en   (accept),
      .rd_addr (req_bucket),
      .rd_data (row_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= chd_pkg::ST_IDLE;
         hash_mode_ff   <= 1'b0;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int b = 0; b < chd_pkg::BUCKETS; b++) begin
            bucket_fill_ff[b] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= (state_ff == chd_pkg::ST_UPDATE);
         if (csr_valid && csr_ready) begin
            hash_mode_ff <= csr_hash_mode;
         end
         if (fill_clr) begin
            for (int b = 0; b < chd_pkg::BUCKETS; b++) begin
               bucket_fill_ff[b] <= '0;
            end
         end else if (fill_we) begin
            bucket_fill_ff[bucket_ff] <= fill_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= chd_pkg::cmd_type'(req_cmd);
         key_ff    <= req_key;
         value_ff  <= req_value_in;
         bucket_ff <= req_bucket;
      end
      if (state_ff == chd_pkg::ST_COMPARE) begin
         hit_vec_ff <= hit_vec_in;
         fill_ff    <= bucket_fill_ff[bucket_ff];
      end
      if (state_ff == chd_pkg::ST_UPDATE) begin
         rsp_found_ff <= rsp_found_in;
         rsp_value_ff <= rsp_value_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = chd_pkg::ST_COMPARE;
            end
         end
         chd_pkg::ST_COMPARE: begin
            state_in = chd_pkg::ST_UPDATE;
         end
         chd_pkg::ST_UPDATE: begin
            state_in = chd_pkg::ST_IDLE;
         end
         default: begin
            state_in = chd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int j = 0; j < chd_pkg::SLOTS_PER_BUCKET; j++) begin
         slot_key[j]   = row_rd[j*chd_pkg::ENTRY_BITS +: chd_pkg::KEY_BITS];
         slot_value[j] = row_rd[j*chd_pkg::ENTRY_BITS + chd_pkg::KEY_BITS +:
                                chd_pkg::VALUE_BITS];
      end
   end

   always_comb begin
      for (int j = 0; j < chd_pkg::SLOTS_PER_BUCKET; j++) begin
         hit_vec_in[j] = (chd_pkg::FILL_BITS'(j) < bucket_fill_ff[bucket_ff]) &&
                         (slot_key[j] == key_ff);
      end
   end

   always_comb begin
      hit_idx = '0;
      for (int j = chd_pkg::SLOTS_PER_BUCKET - 1; j >= 0; j--) begin
         if (hit_vec_ff[j]) begin
            hit_idx = chd_pkg::SLOT_BITS'(j);
         end
      end
      hit_any  = |hit_vec_ff;
      last_idx = chd_pkg::SLOT_BITS'(fill_ff - 1'b1);
      free_idx = chd_pkg::SLOT_BITS'(fill_ff);

      for (int j = 0; j < chd_pkg::SLOTS_PER_BUCKET; j++) begin
         new_key[j]   = slot_key[j];
         new_value[j] = slot_value[j];
      end
      row_we         = 1'b0;
      fill_we        = 1'b0;
      fill_clr       = 1'b0;
      fill_new       = fill_ff;
      entry_count_in = entry_count_ff;
      rsp_found_in   = 1'b0;
      rsp_full_in    = 1'b0;

      if (state_ff == chd_pkg::ST_UPDATE) begin
         unique case (cmd_ff)
            chd_pkg::CMD_LOOKUP: begin
               rsp_found_in = hit_any;
            end
            chd_pkg::CMD_REPLACE, chd_pkg::CMD_ABSENT: begin
               rsp_found_in = hit_any;
               if (hit_any) begin
                  if (cmd_ff == chd_pkg::CMD_REPLACE) begin
                     new_value[hit_idx] = value_ff;
                     row_we             = 1'b1;
                  end
               end else if (fill_ff == chd_pkg::FILL_BITS'(chd_pkg::SLOTS_PER_BUCKET)) begin
                  rsp_full_in = 1'b1;
               end else begin
                  new_key[free_idx]   = key_ff;
                  new_value[free_idx] = value_ff;
                  row_we              = 1'b1;
                  fill_we             = 1'b1;
                  fill_new            = fill_ff + 1'b1;
                  entry_count_in      = entry_count_ff + 1'b1;
               end
            end
            chd_pkg::CMD_DELETE: begin
               rsp_found_in = hit_any;
               if (hit_any) begin
                  new_key[hit_idx]   = slot_key[last_idx];
                  new_value[hit_idx] = slot_value[last_idx];
                  row_we             = 1'b1;
                  fill_we            = 1'b1;
                  fill_new           = fill_ff - 1'b1;
                  if (entry_count_ff != '0) begin
                     entry_count_in = entry_count_ff - 1'b1;
                  end
               end
            end
            chd_pkg::CMD_CLEAR: begin
               fill_clr       = 1'b1;
               entry_count_in = '0;
            end
            default: begin
               rsp_found_in = 1'b0;
            end
         endcase
      end

      rsp_value_in = rsp_found_in ? slot_value[hit_idx] : '0;

      for (int j = 0; j < chd_pkg::SLOTS_PER_BUCKET; j++) begin
         row_wr[j*chd_pkg::ENTRY_BITS +: chd_pkg::KEY_BITS] = new_key[j];
         row_wr[j*chd_pkg::ENTRY_BITS + chd_pkg::KEY_BITS +: chd_pkg::VALUE_BITS] =
            new_value[j];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_bucket_full = rsp_full_ff;
   assign rsp_entry_count = entry_count_ff;

   `CHD_ASSERT_NEXT(a_accept_compare, accept, state_ff == chd_pkg::ST_COMPARE, "Accepted item did not enter the compare cycle.")
   `CHD_ASSERT_NEXT(a_update_result, state_ff == chd_pkg::ST_UPDATE, rsp_valid_ff && !busy, "Write-back cycle gave no result.")
   `CHD_ASSERT_SAME(a_single_hit, state_ff == chd_pkg::ST_UPDATE, $onehot0(hit_vec_ff), "A key matched more than one used slot of its bucket.")
   `CHD_ASSERT_SAME(a_count_range, 1'b1, entry_count_ff <= chd_pkg::COUNT_BITS'(chd_pkg::TOTAL_SLOTS), "Entry count exceeds the table size.")

endmodule

### tb/sv/chained_hash_dictionary_tb.sv
// Self-checking testbench for the chained hash dictionary, with its own dictionary predictor.
module chained_hash_dictionary_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                           found;
      logic [chd_pkg::VALUE_BITS-1:0] value_out;
      logic                           bucket_full;
      logic [chd_pkg::COUNT_BITS-1:0] entry_count;
   } dict_result_type;

   typedef struct packed {
      logic [chd_pkg::CMD_BITS-1:0]   cmd;
      logic [chd_pkg::KEY_BITS-1:0]   key;
      logic [chd_pkg::VALUE_BITS-1:0] value;
      logic                           typed;
      dict_result_type                want;
   } stim_row_type;

   localparam logic [chd_pkg::CMD_BITS-1:0] CMD_UNUSED_MIN = 3'd5;
   localparam logic [chd_pkg::CMD_BITS-1:0] CMD_UNUSED_MAX = 3'd7;
   localparam dict_result_type UNTYPED = '0;
   localparam int DIRECTED_COUNT = 24;
   localparam int POOL_SIZE = 32;

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{chd_pkg::CMD_LOOKUP,  32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0, 8'd0}},
      '{chd_pkg::CMD_DELETE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0, 8'd0}},
      '{chd_pkg::CMD_REPLACE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0, 8'd1}},
      '{chd_pkg::CMD_LOOKUP,  32'h0000_0000, 32'h0000_0000, 1'b1,
        '{1'b1, 32'hFFFF_FFFF, 1'b0, 8'd1}},
      '{chd_pkg::CMD_REPLACE, 32'h0000_0000, 32'h1234_5678, 1'b0, UNTYPED},
      '{chd_pkg::CMD_ABSENT,  32'h0000_0000, 32'h0000_0005, 1'b0, UNTYPED},
      '{chd_pkg::CMD_ABSENT,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, UNTYPED},
      '{chd_pkg::CMD_ABSENT,  32'h0000_000F, 32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{chd_pkg::CMD_REPLACE, 32'h8000_000F, 32'h8000_0000, 1'b0, UNTYPED},
      '{chd_pkg::CMD_REPLACE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, UNTYPED},
      '{chd_pkg::CMD_ABSENT,  32'h1234_567F, 32'h0F0F_0F0F, 1'b0, UNTYPED},
      '{chd_pkg::CMD_ABSENT,  32'h0000_001F, 32'hF0F0_F0F0, 1'b0, UNTYPED},
      '{chd_pkg::CMD_REPLACE, 32'hFFFF_FFEF, 32'h0000_0001, 1'b0, UNTYPED},
      '{chd_pkg::CMD_ABSENT,  32'hA5A5_A5AF, 32'h5A5A_5A5A, 1'b0, UNTYPED},
      '{chd_pkg::CMD_ABSENT,  32'hAAAA_AAAF, 32'h0000_0001, 1'b1, '{1'b0, 32'h0, 1'b1, 8'd9}},
      '{chd_pkg::CMD_REPLACE, 32'h5555_555F, 32'h0000_0002, 1'b1, '{1'b0, 32'h0, 1'b1, 8'd9}},
      '{chd_pkg::CMD_DELETE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, UNTYPED},
      '{chd_pkg::CMD_LOOKUP,  32'hA5A5_A5AF, 32'h0000_0000, 1'b0, UNTYPED},
      '{chd_pkg::CMD_ABSENT,  32'h5555_555F, 32'h0000_0003, 1'b0, UNTYPED},
      '{chd_pkg::CMD_REPLACE, 32'h0000_000F, 32'h0000_0006, 1'b0, UNTYPED},
      '{CMD_UNUSED_MIN,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{CMD_UNUSED_MAX,       32'h0000_0000, 32'h0000_0000, 1'b0, UNTYPED},
      '{chd_pkg::CMD_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0, 8'd0}},
      '{chd_pkg::CMD_LOOKUP,  32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0, 1'b0, 8'd0}}
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [chd_pkg::CMD_BITS-1:0]       req_cmd = '0;
   logic [chd_pkg::KEY_BITS-1:0]       req_key = '0;
   logic [chd_pkg::VALUE_BITS-1:0]     req_value_in = '0;
   logic                               rsp_valid;
   logic                               rsp_found;
   logic [chd_pkg::VALUE_BITS-1:0]     rsp_value_out;
   logic                               rsp_bucket_full;
   logic [chd_pkg::COUNT_BITS-1:0]     rsp_entry_count;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic                               csr_hash_mode = 1'b0;

   // Fixed expectation travelling alongside a directed item.
   logic                               row_typed = 1'b0;
   dict_result_type                    row_want = '0;

   logic                               model_mode = 1'b0;
   int                                 model_fill [chd_pkg::BUCKETS];
   logic [chd_pkg::KEY_BITS-1:0]       model_keys [chd_pkg::TOTAL_SLOTS];
   logic [chd_pkg::VALUE_BITS-1:0]     model_values [chd_pkg::TOTAL_SLOTS];
   int                                 model_total = 0;

   dict_result_type                    expected_q [$];
   logic [chd_pkg::KEY_BITS-1:0]       key_pool [POOL_SIZE];
   int                                 failures = 0;
   int                                 items_taken = 0;
   int                                 results_seen = 0;
   int                                 hits_predicted = 0;
   int                                 refusals_predicted = 0;
   int                                 clears_predicted = 0;

   chained_hash_dictionary u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_value_in    (req_value_in),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_value_out   (rsp_value_out),
      .rsp_bucket_full (rsp_bucket_full),
      .rsp_entry_count (rsp_entry_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_hash_mode   (csr_hash_mode)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("chained_hash_dictionary test failed");
      $finish;
   end

   initial begin
      foreach (model_fill[i]) model_fill[i] = 0;
   end

   task automatic report_failure(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      failures++;
   endtask

   function automatic dict_result_type dictionary_predict(
         input logic [chd_pkg::CMD_BITS-1:0]   cmd,
         input logic [chd_pkg::KEY_BITS-1:0]   key,
         input logic [chd_pkg::VALUE_BITS-1:0] val);
      dict_result_type              res;
      logic [chd_pkg::KEY_BITS-1:0] hashed;
      int                           bucket;
      int                           base;
      int                           fill;
      int                           hit;
      logic                         present;
      res = '0;
      present = 1'b0;
      hit = 0;
      if (cmd == chd_pkg::CMD_CLEAR) begin
         foreach (model_fill[i]) model_fill[i] = 0;
         model_total = 0;
         clears_predicted++;
      end else if (cmd <= chd_pkg::CMD_DELETE) begin
         hashed = model_mode ? (key >> chd_pkg::HASH_SHIFT) : key;
         bucket = int'(hashed % chd_pkg::BUCKETS);
         base = bucket * chd_pkg::SLOTS_PER_BUCKET;
         fill = model_fill[bucket];
         for (int j = 0; j < fill; j++) begin
            if (!present && model_keys[base + j] == key) begin
               present = 1'b1;
               hit = j;
            end
         end
         if (present) begin
            res.found = 1'b1;
            res.value_out = model_values[base + hit];
            hits_predicted++;
         end
         if (cmd == chd_pkg::CMD_REPLACE || cmd == chd_pkg::CMD_ABSENT) begin
            if (present) begin
               if (cmd == chd_pkg::CMD_REPLACE) model_values[base + hit] = val;
            end else if (fill >= chd_pkg::SLOTS_PER_BUCKET) begin
               res.bucket_full = 1'b1;
               refusals_predicted++;
            end else begin
               model_keys[base + fill] = key;
               model_values[base + fill] = val;
               model_fill[bucket] = fill + 1;
               model_total++;
            end
         end else if (cmd == chd_pkg::CMD_DELETE && present) begin
            model_keys[base + hit] = model_keys[base + fill - 1];
            model_values[base + hit] = model_values[base + fill - 1];
            model_fill[bucket] = fill - 1;
            if (model_total > 0) model_total--;
         end
      end
      res.entry_count = chd_pkg::COUNT_BITS'(model_total);
      return res;
   endfunction

   always @(posedge clock) begin : result_checker
      dict_result_type got;
      dict_result_type want;
      dict_result_type predicted;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            got = '{rsp_found, rsp_value_out, rsp_bucket_full, rsp_entry_count};
            results_seen++;
            if (expected_q.size() == 0) begin
               report_failure($sformatf("result %0d arrived with nothing expected",
                                        results_seen));
            end else begin
               want = expected_q.pop_front();
               if (got.found !== want.found)
                  report_failure($sformatf("result %0d found: got %b, expected %b",
                                           results_seen, got.found, want.found));
               if (got.value_out !== want.value_out)
                  report_failure($sformatf("result %0d value_out: got %h, expected %h",
                                           results_seen, got.value_out, want.value_out));
               if (got.bucket_full !== want.bucket_full)
                  report_failure($sformatf("result %0d bucket_full: got %b, expected %b",
                                           results_seen, got.bucket_full, want.bucket_full));
               if (got.entry_count !== want.entry_count)
                  report_failure($sformatf("result %0d entry_count: got %0d, expected %0d",
                                           results_seen, got.entry_count, want.entry_count));
            end
         end
         if (csr_valid && csr_ready) model_mode = csr_hash_mode;
         if (start && !busy) begin
            items_taken++;
            predicted = dictionary_predict(req_cmd, req_key, req_value_in);
            expected_q.push_back(row_typed ? row_want : predicted);
         end
      end
   end

   function automatic int pick_gap(input bit with_gaps);
      int roll;
      roll = $urandom_range(0, 99);
      if (!with_gaps || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 9);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input logic [chd_pkg::CMD_BITS-1:0] cmd,
                            input logic [chd_pkg::KEY_BITS-1:0] key,
                            input logic [chd_pkg::VALUE_BITS-1:0] val, input logic typed,
                            input dict_result_type want, input int gap);
      req_cmd <= cmd;
      req_key <= key;
      req_value_in <= val;
      row_typed <= typed;
      row_want <= want;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      row_typed <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_hash_mode(input logic mode);
      csr_valid <= 1'b1;
      csr_hash_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Most pool keys land in a few hot buckets so that buckets fill and overflow.
   task automatic build_key_pool(input logic mode);
      logic [chd_pkg::BUCKET_BITS-1:0] hot [3];
      logic [chd_pkg::KEY_BITS-1:0]    key;
      foreach (hot[i]) hot[i] = chd_pkg::BUCKET_BITS'($urandom);
      foreach (key_pool[i]) begin
         key = $urandom;
         if ($urandom_range(0, 3) != 0) begin
            if (mode)
               key[chd_pkg::BUCKET_BITS+chd_pkg::HASH_SHIFT-1:chd_pkg::HASH_SHIFT] =
                  hot[$urandom_range(0, 2)];
            else key[chd_pkg::BUCKET_BITS-1:0] = hot[$urandom_range(0, 2)];
         end
         key_pool[i] = key;
      end
   endtask

   task automatic run_phase(input int count, input bit with_gaps, input logic mode);
      int                           roll;
      logic [chd_pkg::CMD_BITS-1:0] cmd;
      logic [chd_pkg::KEY_BITS-1:0] key;
      build_key_pool(mode);
      repeat (count) begin
         roll = $urandom_range(0, 99);
         key = ($urandom_range(0, 9) == 0) ? chd_pkg::KEY_BITS'($urandom)
                                           : key_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (roll < 25) cmd = chd_pkg::CMD_LOOKUP;
         else if (roll < 50) cmd = chd_pkg::CMD_REPLACE;
         else if (roll < 75) cmd = chd_pkg::CMD_ABSENT;
         else if (roll < 90) cmd = chd_pkg::CMD_DELETE;
         else if (roll < 91) cmd = chd_pkg::CMD_CLEAR;
         else if (roll < 94)
            cmd = chd_pkg::CMD_BITS'($urandom_range(CMD_UNUSED_MIN, CMD_UNUSED_MAX));
         else begin
            cmd = chd_pkg::CMD_BITS'($urandom_range(chd_pkg::CMD_LOOKUP, chd_pkg::CMD_DELETE));
            key = $urandom;
         end
         send_item(cmd, key, $urandom, 1'b0, UNTYPED, pick_gap(with_gaps));
      end
      drain_results();
   endtask

   // Fills every slot of every bucket, overflows once, probes, then empties the table.
   task automatic fill_whole_table();
      for (int i = 0; i < chd_pkg::TOTAL_SLOTS; i++)
         send_item(chd_pkg::CMD_ABSENT,
                   {chd_pkg::KEY_BITS'($urandom) & ~chd_pkg::KEY_BITS'(8'hFF)} |
                   chd_pkg::KEY_BITS'(i),
                   $urandom, 1'b0, UNTYPED, pick_gap(1'b1));
      send_item(chd_pkg::CMD_REPLACE, $urandom, $urandom, 1'b0, UNTYPED, pick_gap(1'b1));
      repeat (40)
         send_item(chd_pkg::CMD_LOOKUP,
                   chd_pkg::KEY_BITS'($urandom_range(0, chd_pkg::TOTAL_SLOTS - 1)), $urandom,
                   1'b0, UNTYPED, pick_gap(1'b1));
      send_item(chd_pkg::CMD_CLEAR, $urandom, $urandom, 1'b0, UNTYPED, 0);
      drain_results();
   endtask

   initial begin : stimulus
      logic mode;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].value,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want, pick_gap(1'b1));
      drain_results();

      set_hash_mode(1'b1);
      run_phase(230, 1'b1, 1'b1);
      set_hash_mode(1'b0);
      run_phase(230, 1'b0, 1'b0);
      set_hash_mode(1'b0);
      fill_whole_table();
      set_hash_mode(1'b1);
      run_phase(230, 1'b1, 1'b1);
      mode = 1'($urandom);
      set_hash_mode(mode);
      run_phase(230, 1'b1, mode);
      set_hash_mode(1'b0);
      run_phase(230, 1'b1, 1'b0);

      repeat (10) @(posedge clock);
      if (expected_q.size() != 0)
         report_failure($sformatf("%0d expected results never arrived", expected_q.size()));
      $display("Summary: %0d items taken and %0d results checked across both hash modes,",
               items_taken, results_seen);
      $display("         with %0d hits, %0d refused inserts and %0d clears, one pass full.",
               hits_predicted, refusals_predicted, clears_predicted);
      if (failures == 0)
         $display("chained_hash_dictionary test passed");
      else
         $display("chained_hash_dictionary test failed");
      $finish;
   end

endmodule
